>>> sv/bbp_pkg.sv
`default_nettype none
package bbp_pkg;

    localparam int IDX_W   = 2;
    localparam int GAIN_W  = 12;
    localparam int JOY_W   = 10;
    localparam int POS_W   = 16;
    localparam int ANGLE_W = 14;
    localparam int INT_W   = 15;
    localparam int OP_A_W  = 17;
    localparam int PROD_W  = OP_A_W + GAIN_W + 1;
    localparam int ACC_W   = 32;

    // Fixed-point constants with 8 fraction bits; POS_LIMIT is Q8.8.
    localparam logic signed [JOY_W-1:0]   DEADBAND    = 10'sd12;
    localparam logic signed [POS_W-1:0]   POS_LIMIT   = 16'sd14080;
    localparam logic signed [INT_W-1:0]   INT_LIMIT   = 15'sd12800;
    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 14'sd6400;
    localparam logic [GAIN_W-1:0]         K35         = 12'd90;
    localparam logic [GAIN_W-1:0]         K98         = 12'd251;
    localparam logic signed [ACC_W-1:0]   ROUND_HALF  = 32'sd128;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC_D,
        ST_ANGLE,
        ST_SINE,
        ST_SINE_ACC,
        ST_VEL,
        ST_DAMP,
        ST_DAMP_ACC,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [IDX_W-1:0] {
        REG_KP = 2'd0,
        REG_KI = 2'd1,
        REG_KD = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [OP_A_W-1:0] op_a;
        logic [GAIN_W-1:0]        op_b;
        acc_op_t                  acc_op;
    } mac_req_t;

    // sin(k * 0.5 degrees) in Q0.8, k = 0..63.
    function automatic logic [7:0] sine_rom(input logic [5:0] idx);
        logic [7:0] v;
        case (idx)
            6'd0:  v = 8'd0;   6'd1:  v = 8'd2;   6'd2:  v = 8'd4;   6'd3:  v = 8'd7;
            6'd4:  v = 8'd9;   6'd5:  v = 8'd11;  6'd6:  v = 8'd13;  6'd7:  v = 8'd16;
            6'd8:  v = 8'd18;  6'd9:  v = 8'd20;  6'd10: v = 8'd22;  6'd11: v = 8'd25;
            6'd12: v = 8'd27;  6'd13: v = 8'd29;  6'd14: v = 8'd31;  6'd15: v = 8'd33;
            6'd16: v = 8'd36;  6'd17: v = 8'd38;  6'd18: v = 8'd40;  6'd19: v = 8'd42;
            6'd20: v = 8'd44;  6'd21: v = 8'd47;  6'd22: v = 8'd49;  6'd23: v = 8'd51;
            6'd24: v = 8'd53;  6'd25: v = 8'd55;  6'd26: v = 8'd58;  6'd27: v = 8'd60;
            6'd28: v = 8'd62;  6'd29: v = 8'd64;  6'd30: v = 8'd66;  6'd31: v = 8'd68;
            6'd32: v = 8'd71;  6'd33: v = 8'd73;  6'd34: v = 8'd75;  6'd35: v = 8'd77;
            6'd36: v = 8'd79;  6'd37: v = 8'd81;  6'd38: v = 8'd83;  6'd39: v = 8'd85;
            6'd40: v = 8'd88;  6'd41: v = 8'd90;  6'd42: v = 8'd92;  6'd43: v = 8'd94;
            6'd44: v = 8'd96;  6'd45: v = 8'd98;  6'd46: v = 8'd100; 6'd47: v = 8'd102;
            6'd48: v = 8'd104; 6'd49: v = 8'd106; 6'd50: v = 8'd108; 6'd51: v = 8'd110;
            6'd52: v = 8'd112; 6'd53: v = 8'd114; 6'd54: v = 8'd116; 6'd55: v = 8'd118;
            6'd56: v = 8'd120; 6'd57: v = 8'd122; 6'd58: v = 8'd124; 6'd59: v = 8'd126;
            6'd60: v = 8'd128; 6'd61: v = 8'd130; 6'd62: v = 8'd132; 6'd63: v = 8'd134;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> sv/bbp_mac.sv
`default_nettype none
module bbp_mac (
    input  wire logic                              aclk,
    input  wire bbp_pkg::mac_req_t                 req,
    output logic signed [bbp_pkg::ACC_W-1:0]       acc
);
    import bbp_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // The product is registered; the accumulator folds it in on the next cycle.
    always_ff @(posedge aclk) begin
        prod_reg <= req.op_a * $signed({1'b0, req.op_b});
        case (req.acc_op)
            ACC_LOAD: acc_reg <= ACC_W'(prod_reg);
            ACC_ADD:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            default:  acc_reg <= acc_reg;
        endcase
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

>>> sv/ball_beam_pid_plant_step_top.sv
// A tick inside the deadband runs the full sequence of states; a held tick or a restart goes
// from PREP straight to FINISH. A new item is taken only in IDLE, after the last result is
// loaded into the output register, which waits on m_tready. The sequence length is set by
// the single multiply-accumulate unit that the sequencer steps through five products.
// Reset (aresetn low, synchronous) clears the gains, the ball state and the result valid.
`default_nettype none
module ball_beam_pid_plant_step_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,   // [9:0] joystick_x
    input  wire logic [0:0]                    s_tuser,   // [0] op
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,   // [13:0] beam_angle, [29:14] ball_position
    output logic [0:0]                         m_tuser,   // [0] released
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bbp_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [bbp_pkg::GAIN_W-1:0]    cfg_wdata
);
    import bbp_pkg::*;

    state_t state_reg, state_next;

    logic [GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    logic              op_reg;
    logic signed [JOY_W-1:0]   joy_reg;
    logic signed [POS_W-1:0]   ball_pos_reg;
    logic signed [POS_W-1:0]   ball_vel_reg;
    logic signed [INT_W-1:0]   integral_reg;
    logic signed [INT_W-1:0]   last_err_reg;
    logic signed [POS_W-1:0]   deriv_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic signed [OP_A_W-1:0]  vel_reg;
    logic                      rel_reg;

    logic                      m_valid_reg;
    logic signed [ANGLE_W-1:0] m_angle_reg;
    logic signed [POS_W-1:0]   m_pos_reg;
    logic                      m_rel_reg;

    mac_req_t                req;
    logic signed [ACC_W-1:0] acc;
    logic                    out_free;
    logic                    in_xfer;

    bbp_mac u_mac (
        .aclk (aclk),
        .req  (req),
        .acc  (acc)
    );

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // ---------------- datapath arithmetic ----------------
    logic                      held;
    logic signed [17:0]        hold_sum;
    logic signed [POS_W-1:0]   hold_pos;
    logic signed [POS_W-1:0]   rel_pos;
    logic signed [POS_W-1:0]   neg_pos;
    logic signed [INT_W-1:0]   err;
    logic signed [POS_W-1:0]   int_sum;
    logic signed [INT_W-1:0]   int_new;
    logic signed [POS_W-1:0]   deriv;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [23:0]        acc_scaled;
    logic signed [ANGLE_W-1:0] angle_clamped;
    logic [ANGLE_W-2:0]        angle_mag;
    logic [ANGLE_W-1:0]        idx_sum;
    logic [5:0]                sine_idx;
    logic [7:0]                sine_mag;
    logic signed [8:0]         sine_val;
    logic signed [OP_A_W-1:0]  vel_sum;
    logic signed [POS_W-1:0]   damp_vel;
    logic signed [OP_A_W-1:0]  pos_sum;
    logic signed [POS_W-1:0]   pos_new;

    always_comb begin
        held = (joy_reg > DEADBAND) || (joy_reg < -DEADBAND);

        // Dragged ball: moves by three times the joystick reading, clamped to the beam.
        hold_sum = 18'(ball_pos_reg) + 18'(joy_reg) + (18'(joy_reg) <<< 1);
        if (hold_sum > 18'(POS_LIMIT)) begin
            hold_pos = POS_LIMIT;
        end else if (hold_sum < -18'(POS_LIMIT)) begin
            hold_pos = -POS_LIMIT;
        end else begin
            hold_pos = hold_sum[POS_W-1:0];
        end

        if (ball_pos_reg > POS_LIMIT) begin
            rel_pos = POS_LIMIT;
        end else if (ball_pos_reg < -POS_LIMIT) begin
            rel_pos = -POS_LIMIT;
        end else begin
            rel_pos = ball_pos_reg;
        end
        neg_pos = -rel_pos;
        err     = neg_pos[INT_W-1:0];

        int_sum = POS_W'(integral_reg) + POS_W'(err);
        if (int_sum > POS_W'(INT_LIMIT)) begin
            int_new = INT_LIMIT;
        end else if (int_sum < -POS_W'(INT_LIMIT)) begin
            int_new = -INT_LIMIT;
        end else begin
            int_new = int_sum[INT_W-1:0];
        end
        deriv = POS_W'(err) - POS_W'(last_err_reg);

        // Rescale rounds half up; an arithmetic shift gives exactly that.
        acc_rnd    = acc + ROUND_HALF;
        acc_scaled = acc_rnd[ACC_W-1:8];

        if (acc_scaled > 24'(ANGLE_LIMIT)) begin
            angle_clamped = ANGLE_LIMIT;
        end else if (acc_scaled < -24'(ANGLE_LIMIT)) begin
            angle_clamped = -ANGLE_LIMIT;
        end else begin
            angle_clamped = acc_scaled[ANGLE_W-1:0];
        end

        angle_mag = angle_reg[ANGLE_W-1] ? (ANGLE_W-1)'(-angle_reg) : (ANGLE_W-1)'(angle_reg);
        idx_sum   = {1'b0, angle_mag} + ANGLE_W'(64);
        sine_idx  = (idx_sum[ANGLE_W-1:7] > 7'd63) ? 6'd63 : idx_sum[12:7];
        sine_mag  = sine_rom(sine_idx);
        sine_val  = angle_reg[ANGLE_W-1] ? -$signed({1'b0, sine_mag})
                                         : $signed({1'b0, sine_mag});

        vel_sum = OP_A_W'(ball_vel_reg) + acc_scaled[OP_A_W-1:0];

        if (acc_scaled > 24'sd32767) begin
            damp_vel = 16'sh7FFF;
        end else if (acc_scaled < -24'sd32768) begin
            damp_vel = 16'sh8000;
        end else begin
            damp_vel = acc_scaled[POS_W-1:0];
        end

        pos_sum = OP_A_W'(ball_pos_reg) + OP_A_W'(damp_vel);
        if (pos_sum > 17'sd32767) begin
            pos_new = 16'sh7FFF;
        end else if (pos_sum < -17'sd32768) begin
            pos_new = 16'sh8000;
        end else begin
            pos_new = pos_sum[POS_W-1:0];
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_xfer) state_next = ST_PREP;
            ST_PREP:     state_next = (op_reg || held) ? ST_FINISH : ST_MUL_P;
            ST_MUL_P:    state_next = ST_MUL_I;
            ST_MUL_I:    state_next = ST_MUL_D;
            ST_MUL_D:    state_next = ST_ACC_D;
            ST_ACC_D:    state_next = ST_ANGLE;
            ST_ANGLE:    state_next = ST_SINE;
            ST_SINE:     state_next = ST_SINE_ACC;
            ST_SINE_ACC: state_next = ST_VEL;
            ST_VEL:      state_next = ST_DAMP;
            ST_DAMP:     state_next = ST_DAMP_ACC;
            ST_DAMP_ACC: state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_FINISH;
            ST_FINISH:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == ST_IDLE);
        req.op_a   = '0;
        req.op_b   = '0;
        req.acc_op = ACC_HOLD;
        case (state_reg)
            ST_MUL_P: begin
                req.op_a = OP_A_W'(last_err_reg);
                req.op_b = kp_reg;
            end
            ST_MUL_I: begin
                req.op_a   = OP_A_W'(integral_reg);
                req.op_b   = ki_reg;
                req.acc_op = ACC_LOAD;
            end
            ST_MUL_D: begin
                req.op_a   = OP_A_W'(deriv_reg);
                req.op_b   = kd_reg;
                req.acc_op = ACC_ADD;
            end
            ST_ACC_D: req.acc_op = ACC_ADD;
            ST_SINE: begin
                req.op_a = OP_A_W'(sine_val);
                req.op_b = K35;
            end
            ST_SINE_ACC: req.acc_op = ACC_LOAD;
            ST_DAMP: begin
                req.op_a = vel_reg;
                req.op_b = K98;
            end
            ST_DAMP_ACC: req.acc_op = ACC_LOAD;
            default: req.acc_op = ACC_HOLD;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
            ball_pos_reg <= '0;
            ball_vel_reg <= '0;
            integral_reg <= '0;
            last_err_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                case (cfg_reg_t'(cfg_index))
                    REG_KP:  kp_reg <= cfg_wdata;
                    REG_KI:  ki_reg <= cfg_wdata;
                    REG_KD:  kd_reg <= cfg_wdata;
                    default: kp_reg <= kp_reg;
                endcase
            end

            case (state_reg)
                ST_PREP: begin
                    if (op_reg) begin
                        ball_pos_reg <= '0;
                        ball_vel_reg <= '0;
                        integral_reg <= '0;
                        last_err_reg <= '0;
                    end else if (held) begin
                        ball_pos_reg <= hold_pos;
                        ball_vel_reg <= '0;
                        integral_reg <= '0;
                        last_err_reg <= '0;
                    end else begin
                        ball_pos_reg <= rel_pos;
                        integral_reg <= int_new;
                        last_err_reg <= err;
                    end
                end
                ST_UPDATE: begin
                    ball_vel_reg <= damp_vel;
                    ball_pos_reg <= pos_new;
                end
                default: ball_pos_reg <= ball_pos_reg;
            endcase

            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            op_reg  <= s_tuser[0];
            joy_reg <= $signed(s_tdata[JOY_W-1:0]);
        end
        case (state_reg)
            ST_PREP: begin
                deriv_reg <= deriv;
                angle_reg <= '0;
                rel_reg   <= !op_reg && !held;
            end
            ST_ANGLE: angle_reg <= angle_clamped;
            ST_VEL:   vel_reg   <= vel_sum;
            default:  deriv_reg <= deriv_reg;
        endcase
        if (state_reg == ST_FINISH && out_free) begin
            m_angle_reg <= angle_reg;
            m_pos_reg   <= ball_pos_reg;
            m_rel_reg   <= rel_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {2'b00, m_pos_reg, m_angle_reg};
    assign m_tuser   = m_rel_reg;

    // ---------------- assertions ----------------
    a_held_angle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_rel_reg |-> m_angle_reg == '0)
        else $error("held or restart result carries a nonzero beam angle");

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_angle_reg <= ANGLE_LIMIT) && (m_angle_reg >= -ANGLE_LIMIT))
        else $error("beam angle outside the clamp");

    a_integral_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (integral_reg <= INT_LIMIT) && (integral_reg >= -INT_LIMIT))
        else $error("integral outside the clamp");

    a_pos_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL_P |-> (ball_pos_reg <= POS_LIMIT) && (ball_pos_reg >= -POS_LIMIT))
        else $error("ball position not clamped before the controller runs");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready && !$stable(state_reg))
        else $error("input taken while the sequencer is busy");

endmodule
`default_nettype wire

>>> tb/ball_beam_pid_plant_step_top_tb.sv
`default_nettype none
module ball_beam_pid_plant_step_top_tb;
    import bbp_pkg::*;

    localparam longint FRAC        = 8;
    localparam longint ONE_Q       = 256;
    localparam longint HALF_Q      = ONE_Q / 2;
    localparam longint DEADBAND_Q  = ONE_Q * 5 / 100;
    localparam longint POS_LIM_Q   = 55 * ONE_Q;
    localparam longint INT_LIM_Q   = 50 * ONE_Q;
    localparam longint ANGLE_LIM_Q = 25 * ONE_Q;
    localparam longint K35_Q       = (35 * ONE_Q + 50) / 100;
    localparam longint K98_Q       = (98 * ONE_Q + 50) / 100;
    localparam longint SINE_DEPTH  = 64;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam logic [IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int REPORT_LIMIT = 200;

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [POS_W-1:0]   pos;
        logic                      released;
    } beam_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    wire logic           s_tready;
    logic [15:0]         s_tdata = '0;    // [9:0] joystick_x
    logic [0:0]          s_tuser = '0;    // [0] op
    wire logic           m_tvalid;
    logic                m_tready = 1'b0;
    wire logic [31:0]    m_tdata;         // [13:0] beam_angle, [29:14] ball_position
    wire logic [0:0]     m_tuser;         // [0] released
    logic                cfg_valid = 1'b0;
    wire logic           cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [GAIN_W-1:0]   cfg_wdata = '0;

    // Predicted plant and controller state.
    logic signed [POS_W-1:0] ball_pos_q = '0;
    logic signed [POS_W-1:0] ball_vel_q = '0;
    logic signed [INT_W-1:0] integ_q = '0;
    logic signed [INT_W-1:0] last_err_q = '0;
    logic [GAIN_W-1:0]       gain_p = '0;
    logic [GAIN_W-1:0]       gain_i = '0;
    logic [GAIN_W-1:0]       gain_d = '0;

    beam_result_t beam_results_due[$];
    beam_result_t due;
    int  failures = 0;
    int  quiet_cycles = 0;
    bit  idle_en = 1'b1;

    ball_beam_pid_plant_step_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint sat_to(input longint x, input int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    function automatic longint clamp_to(input longint x, input longint lim);
        return x > lim ? lim : (x < -lim ? -lim : x);
    endfunction

    // Divide by 2^FRAC, rounding half toward plus infinity.
    function automatic longint rescale_q(input longint x);
        return (x + HALF_Q) >>> FRAC;
    endfunction

    // Sine of k half-degree steps, from a Taylor series in Q2.30.
    function automatic longint sine_entry_q(input longint unsigned k);
        longint unsigned x, x2, t;
        longint acc;
        x = k * 32 * PI_Q30 / (180 * SINE_DEPTH);
        x2 = (x * x) >> 30;
        t = x;
        acc = longint'(x);
        t = ((t * x2) >> 30) / 6;  acc -= longint'(t);
        t = ((t * x2) >> 30) / 20; acc += longint'(t);
        t = ((t * x2) >> 30) / 42; acc -= longint'(t);
        t = ((t * x2) >> 30) / 72; acc += longint'(t);
        return (acc + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
    endfunction

    function automatic longint sine_of_angle(input longint angle);
        longint mag, idx, v;
        mag = angle < 0 ? -angle : angle;
        idx = (mag * SINE_DEPTH + 16 * ONE_Q) / (32 * ONE_Q);
        if (idx > SINE_DEPTH - 1) idx = SINE_DEPTH - 1;
        v = sine_entry_q(idx);
        return angle < 0 ? -v : v;
    endfunction

    // One control tick of the beam: updates the predicted state, returns the result.
    function automatic beam_result_t advance_plant(input logic op,
                                                   input logic signed [JOY_W-1:0] joy);
        beam_result_t res;
        longint j, p, err, d, a, v, ig;
        res.angle = '0;
        res.pos = '0;
        res.released = 1'b0;
        if (op) begin
            ball_pos_q = '0;
            ball_vel_q = '0;
            integ_q = '0;
            last_err_q = '0;
            return res;
        end
        j = longint'(joy);
        a = 0;
        if ((j < 0 ? -j : j) > DEADBAND_Q) begin
            p = clamp_to(longint'(ball_pos_q) + 3 * j, POS_LIM_Q);
            ball_pos_q = POS_W'(sat_to(p, POS_W));
            ball_vel_q = '0;
            integ_q = '0;
            last_err_q = '0;
        end else begin
            res.released = 1'b1;
            p = clamp_to(longint'(ball_pos_q), POS_LIM_Q);
            err = -p;
            ig = sat_to(clamp_to(longint'(integ_q) + err, INT_LIM_Q), INT_W);
            integ_q = INT_W'(ig);
            d = err - longint'(last_err_q);
            a = rescale_q(longint'(gain_p) * err + longint'(gain_i) * ig
                          + longint'(gain_d) * d);
            a = clamp_to(a, ANGLE_LIM_Q);
            last_err_q = INT_W'(sat_to(err, INT_W));
            v = longint'(ball_vel_q) + rescale_q(sine_of_angle(a) * K35_Q);
            v = sat_to(rescale_q(v * K98_Q), POS_W);
            ball_vel_q = POS_W'(v);
            ball_pos_q = POS_W'(sat_to(p + v, POS_W));
        end
        res.angle = ANGLE_W'(sat_to(a, ANGLE_W));
        res.pos = ball_pos_q;
        return res;
    endfunction

    function automatic int draw_idle();
        return idle_en ? $urandom_range(12, 0) : 0;
    endfunction

    task automatic send_beam_item(input logic op, input logic signed [JOY_W-1:0] joy);
        int gap;
        gap = draw_idle();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, joy};
        s_tuser <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beam_results_due.push_back(advance_plant(op, joy));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (beam_results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_KP:  gain_p = val;
            REG_KI:  gain_i = val;
            REG_KD:  gain_d = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] kp, ki, kd);
        drain_results();
        cfg_write(REG_KP, kp);
        cfg_write(REG_KI, ki);
        cfg_write(REG_KD, kd);
    endtask

    // With all gains at their reset value the ball rests; restarts ignore the joystick.
    task automatic test_restart_at_rest();
        send_beam_item(1'b0, 10'sd0);
        send_beam_item(1'b0, 10'sd12);
        send_beam_item(1'b0, -10'sd12);
        send_beam_item(1'b1, 10'sd0);
        send_beam_item(1'b1, -10'sd512);
    endtask

    // Dragging just outside the deadband, full deflection until the +55 clamp, then one full drag back.
    task automatic test_drag_to_limits();
        send_beam_item(1'b0, 10'sd13);
        send_beam_item(1'b0, -10'sd13);
        repeat (10) send_beam_item(1'b0, 10'sd511);
        send_beam_item(1'b0, -10'sd512);
    endtask

    // Drag to +52, then release with all gains at maximum: integral and angle saturate.
    task automatic test_closed_loop_saturation();
        send_beam_item(1'b0, 10'sd256);
        set_gains(12'hFFF, 12'hFFF, 12'hFFF);
        cfg_write(CFG_IDX_SPARE, 12'($urandom));
        send_beam_item(1'b0, 10'sd0);
        send_beam_item(1'b0, 10'sd7);
        send_beam_item(1'b0, -10'sd12);
        send_beam_item(1'b0, 10'sd12);
        send_beam_item(1'b1, 10'sd0);
    endtask

    // Mostly released ticks so the loop runs long, with drags and restarts mixed in.
    task automatic run_random_phase(input logic [GAIN_W-1:0] kp, ki, kd,
                                    input int count, input bit with_idle);
        int r;
        logic op;
        logic signed [JOY_W-1:0] joy;
        set_gains(kp, ki, kd);
        idle_en = with_idle;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain_results();
            r = $urandom_range(99, 0);
            if (r < 6) begin
                op = 1'b1;
                joy = JOY_W'($urandom);
            end else if (r < 22) begin
                op = 1'b0;
                joy = JOY_W'($urandom);
            end else begin
                op = 1'b0;
                joy = JOY_W'($urandom_range(2 * DEADBAND_Q, 0) - DEADBAND_Q);
            end
            send_beam_item(op, joy);
        end
        idle_en = 1'b1;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (beam_results_due.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: result transfer with none expected: expected none, actual %h/%b",
                             $time, m_tdata, m_tuser);
            end else begin
                due = beam_results_due.pop_front();
                check_field("beam_angle", due.angle, $signed(m_tdata[13:0]));
                check_field("ball_position", due.pos, $signed(m_tdata[29:14]));
                check_field("released", due.released, m_tuser[0]);
            end
        end
    end

    initial begin : result_sink
        int n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            n = draw_idle();
            if (n > 0) begin
                m_tready <= 1'b0;
                @(posedge aclk);
                while (!m_tvalid) @(posedge aclk);
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("ball_beam_pid_plant_step_top_tb: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_restart_at_rest();
        test_drag_to_limits();
        test_closed_loop_saturation();

        run_random_phase(12'd0, 12'd0, 12'd0, 115, 1'b1);
        run_random_phase(12'hFFF, 12'hFFF, 12'hFFF, 115, 1'b0);
        run_random_phase(12'd300, 12'd1, 12'd800, 115, 1'b1);
        run_random_phase(12'($urandom), 12'($urandom_range(64, 0)), 12'($urandom), 115, 1'b1);
        run_random_phase(12'hFFF, 12'd0, 12'd0, 115, 1'b0);
        run_random_phase(12'($urandom), 12'($urandom), 12'($urandom), 115, 1'b1);

        drain_results();
        repeat (20) @(posedge aclk);
        if (failures == 0)
            $display("ball_beam_pid_plant_step_top_tb: PASS");
        else
            $display("ball_beam_pid_plant_step_top_tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
sv/bbp_pkg.sv
sv/bbp_mac.sv
sv/ball_beam_pid_plant_step_top.sv
tb/ball_beam_pid_plant_step_top_tb.sv
